/* src/npcs_pkg.sv */
`default_nettype none
package npcs_pkg;

    localparam int CH_W      = 8;
    localparam int SQ_W      = 2 * CH_W;
    localparam int DIST_W    = 18;
    localparam int IDX_W     = 8;
    localparam int ENTRY_W   = 3 * CH_W;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;
    localparam int M_PAD_W   = M_TDATA_W - DIST_W - IDX_W;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic valid;
        logic last;
    } beat_ctl_t;

endpackage
`default_nettype wire

/* src/npcs_ram.sv */
`default_nettype none
module npcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* src/npcs_dist.sv */
`default_nettype none
module npcs_dist (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [npcs_pkg::CH_W-1:0]    q_red,
    input  wire logic [npcs_pkg::CH_W-1:0]    q_green,
    input  wire logic [npcs_pkg::CH_W-1:0]    q_blue,
    input  wire logic [npcs_pkg::ENTRY_W-1:0] entry,
    input  wire npcs_pkg::beat_ctl_t          in_ctl,
    output logic      [npcs_pkg::DIST_W-1:0]  sum_sq,
    output npcs_pkg::beat_ctl_t               out_ctl
);

    localparam int CW = npcs_pkg::CH_W;
    localparam int SW = npcs_pkg::SQ_W;
    localparam int DW = npcs_pkg::DIST_W;

    logic [CW-1:0] d_r, d_g, d_b;
    logic [CW-1:0] e_r, e_g, e_b;
    logic [SW-1:0] sq_r_reg, sq_g_reg, sq_b_reg;
    logic [DW-1:0] dist_reg;
    npcs_pkg::beat_ctl_t sq_ctl_reg, dist_ctl_reg;

    assign e_r = entry[3*CW-1:2*CW];
    assign e_g = entry[2*CW-1:CW];
    assign e_b = entry[CW-1:0];

    always_comb
    begin
        d_r = (q_red   >= e_r) ? (q_red   - e_r) : (e_r - q_red);
        d_g = (q_green >= e_g) ? (q_green - e_g) : (e_g - q_green);
        d_b = (q_blue  >= e_b) ? (q_blue  - e_b) : (e_b - q_blue);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_ctl_reg   <= '0;
            dist_ctl_reg <= '0;
        end
        else
        begin
            sq_ctl_reg   <= in_ctl;
            dist_ctl_reg <= sq_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_r_reg <= SW'(d_r) * SW'(d_r);
        sq_g_reg <= SW'(d_g) * SW'(d_g);
        sq_b_reg <= SW'(d_b) * SW'(d_b);
        dist_reg <= DW'(sq_r_reg) + DW'(sq_g_reg) + DW'(sq_b_reg);
    end

    assign sum_sq  = dist_reg;
    assign out_ctl = dist_ctl_reg;

endmodule
`default_nettype wire

/* src/nearest_palette_color_search.sv */
// Channel   Direction  Signals                         Beat carries
// s_        in         s_tvalid s_tready s_tdata/tuser load entry or query color
// m_        out        m_tvalid m_tready m_tdata       nearest index and distance
// cfg_      in         cfg_valid cfg_ready cfg_data    six_bit_source
//
// A load beat is accepted in the idle state; the block stays ready.
// A query beat holds s_tready low while the block makes one palette read per cycle
// from the single memory read port, then drains three pipeline stages and loads the
// output register once it is free.
// A stalled result waits in the output register; s_tready returns once it is loaded.
// Reset clears control state only; the palette is undefined until loaded.
`default_nettype none
module nearest_palette_color_search #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  wire logic [npcs_pkg::S_TDATA_W-1:0]     s_tdata,
    // action[0]
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // best_index[7:0], best_distance[25:8], zero[31:26]
    output logic      [npcs_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic                               cfg_data
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam int CW = npcs_pkg::CH_W;
    localparam int DW = npcs_pkg::DIST_W;
    localparam int IW = npcs_pkg::IDX_W;

    npcs_pkg::state_t state_reg, state_next;

    logic          six_bit_reg;
    logic [CW-1:0] q_r_reg, q_g_reg, q_b_reg;
    logic [CW-1:0] in_idx, in_r, in_g, in_b;
    logic [AW-1:0] addr_reg, cmp_idx_reg, best_idx_reg, wr_addr;
    logic [DW-1:0] best_dist_reg, out_dist_reg, cand_dist;
    logic [IW-1:0] out_idx_reg;
    logic [AW+IW-1:0] wr_ext, best_ext;
    logic [npcs_pkg::ENTRY_W-1:0] rd_data;
    logic          out_valid_reg;
    logic          accept, load_accept, query_accept, wr_en;
    logic          rd_en, scan_last, out_load, take;
    npcs_pkg::beat_ctl_t rd_ctl_reg, dist_ctl;

    assign in_idx = s_tdata[CW-1:0];
    assign in_r   = s_tdata[2*CW-1:CW];
    assign in_g   = s_tdata[3*CW-1:2*CW];
    assign in_b   = s_tdata[4*CW-1:3*CW];

    assign accept       = s_tvalid && s_tready;
    assign load_accept  = accept && (s_tuser == npcs_pkg::ACT_LOAD);
    assign query_accept = accept && (s_tuser == npcs_pkg::ACT_QUERY);
    assign wr_ext       = (AW+IW)'(in_idx);
    assign wr_addr      = wr_ext[AW-1:0];
    assign wr_en        = load_accept && (32'(in_idx) < 32'(PALETTE_ENTRIES));
    assign scan_last    = (addr_reg == AW'(PALETTE_ENTRIES - 1));
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            npcs_pkg::ST_IDLE:
            begin
                if (query_accept)
                begin
                    state_next = npcs_pkg::ST_SCAN;
                end
            end
            npcs_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = npcs_pkg::ST_DRAIN;
                end
            end
            npcs_pkg::ST_DRAIN:
            begin
                if (dist_ctl.valid && dist_ctl.last)
                begin
                    state_next = npcs_pkg::ST_PUSH;
                end
            end
            npcs_pkg::ST_PUSH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = npcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = npcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            npcs_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            npcs_pkg::ST_SCAN:
            begin
                rd_en = 1'b1;
            end
            npcs_pkg::ST_DRAIN:
            begin
                rd_en = 1'b0;
            end
            npcs_pkg::ST_PUSH:
            begin
                out_load = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= npcs_pkg::ST_IDLE;
            six_bit_reg   <= 1'b1;
            addr_reg      <= '0;
            cmp_idx_reg   <= '0;
            rd_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                six_bit_reg <= cfg_data;
            end
            if (query_accept)
            begin
                addr_reg    <= '0;
                cmp_idx_reg <= '0;
            end
            else
            begin
                if (rd_en)
                begin
                    addr_reg <= addr_reg + AW'(1);
                end
                if (dist_ctl.valid)
                begin
                    cmp_idx_reg <= cmp_idx_reg + AW'(1);
                end
            end
            rd_ctl_reg.valid <= rd_en;
            rd_ctl_reg.last  <= rd_en && scan_last;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign take     = dist_ctl.valid && ((cmp_idx_reg == '0) || (cand_dist < best_dist_reg));
    assign best_ext = (AW+IW)'(best_idx_reg);

    always_ff @(posedge clk)
    begin
        if (query_accept)
        begin
            q_r_reg <= six_bit_reg ? {in_r[CW-3:0], 2'b00} : in_r;
            q_g_reg <= six_bit_reg ? {in_g[CW-3:0], 2'b00} : in_g;
            q_b_reg <= six_bit_reg ? {in_b[CW-3:0], 2'b00} : in_b;
        end
        if (take)
        begin
            best_idx_reg  <= cmp_idx_reg;
            best_dist_reg <= cand_dist;
        end
        if (out_load)
        begin
            out_idx_reg  <= best_ext[IW-1:0];
            out_dist_reg <= best_dist_reg;
        end
    end

    npcs_ram #(
        .WIDTH (npcs_pkg::ENTRY_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({in_r, in_g, in_b}),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    npcs_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_red   (q_r_reg),
        .q_green (q_g_reg),
        .q_blue  (q_b_reg),
        .entry   (rd_data),
        .in_ctl  (rd_ctl_reg),
        .sum_sq  (cand_dist),
        .out_ctl (dist_ctl)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{npcs_pkg::M_PAD_W{1'b0}}, out_dist_reg, out_idx_reg};

endmodule
`default_nettype wire

/* src/npcs_checker.sv */
`default_nettype none
module npcs_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [npcs_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                           s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [npcs_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           cfg_valid,
    input wire logic                           cfg_ready,
    input wire logic                           cfg_data
);

    localparam int DW = npcs_pkg::DIST_W;
    localparam int IW = npcs_pkg::IDX_W;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == npcs_pkg::ACT_QUERY) |=> !s_tready)
        else $error("ready after query beat");

    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == npcs_pkg::ACT_LOAD) |=> s_tready)
        else $error("not ready after load beat");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[DW+IW-1:IW] <= DW'(195075)))
        else $error("distance out of range");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result raised while still busy");

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (.*);
`default_nettype wire

/* test/npcs_checker.sv */
`timescale 1ns / 1ps
module npcs_scoreboard
    import npcs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action[0]
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // best_index[7:0], best_distance[25:8], zero[31:26]
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic                 cfg_data,
    output int                   mismatches,
    output int                   pending,
    output int                   queries,
    output int                   loads
);

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } colour_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  index;
    } match_t;

    colour_t palette_copy [PALETTE_ENTRIES];
    logic    six_bit_mode = 1'b1;
    match_t  nearest_q [$];
    int      fail_count = 0;
    int      query_count = 0;
    int      load_count = 0;
    int      waiting = 0;

    assign mismatches = fail_count;
    assign pending    = waiting;
    assign queries    = query_count;
    assign loads      = load_count;

    function automatic logic [DIST_W-1:0] channel_sq(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
        logic [CH_W-1:0] diff;
        logic [SQ_W-1:0] prod;
        diff = (a >= b) ? a - b : b - a;
        prod = diff * diff;
        return DIST_W'(prod);
    endfunction

    function automatic match_t find_nearest(colour_t query);
        colour_t           probe;
        match_t            best;
        logic [DIST_W-1:0] total;
        probe = query;
        if (six_bit_mode)
        begin
            probe.red   = {query.red[5:0], 2'b00};
            probe.green = {query.green[5:0], 2'b00};
            probe.blue  = {query.blue[5:0], 2'b00};
        end
        best = '0;
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            total = channel_sq(probe.red, palette_copy[i].red)
                  + channel_sq(probe.green, palette_copy[i].green)
                  + channel_sq(probe.blue, palette_copy[i].blue);
            if (i == 0 || total < best.distance)
            begin
                best.index    = IDX_W'(i);
                best.distance = total;
            end
        end
        return best;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ns  result mismatch: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        match_t expected;
        if (!rst_n)
        begin
            six_bit_mode = 1'b1;
            nearest_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                six_bit_mode = cfg_data;

            if (m_tvalid && m_tready)
            begin
                if (nearest_q.size() == 0)
                    report_mismatch($sformatf("unexpected result beat %h", m_tdata));
                else
                begin
                    expected = nearest_q.pop_front();
                    if (m_tdata[IDX_W-1:0] !== expected.index)
                        report_mismatch($sformatf("best_index %0d, expected %0d",
                                                  m_tdata[IDX_W-1:0], expected.index));
                    if (m_tdata[IDX_W +: DIST_W] !== expected.distance)
                        report_mismatch($sformatf("best_distance %0d, expected %0d",
                                                  m_tdata[IDX_W +: DIST_W],
                                                  expected.distance));
                    if (m_tdata[M_TDATA_W-1 -: M_PAD_W] !== '0)
                        report_mismatch($sformatf("padding bits %b not zero",
                                                  m_tdata[M_TDATA_W-1 -: M_PAD_W]));
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser == ACT_LOAD)
                begin
                    if (s_tdata[IDX_W-1:0] < PALETTE_ENTRIES)
                        palette_copy[s_tdata[IDX_W-1:0]] = s_tdata[IDX_W +: ENTRY_W];
                    load_count++;
                end
                else
                begin
                    nearest_q.push_back(find_nearest(s_tdata[IDX_W +: ENTRY_W]));
                    query_count++;
                end
            end
        end
        waiting = nearest_q.size();
    end

endmodule

/* test/tb_nearest_palette_color_search.sv */
`timescale 1ns / 1ps
module tb_nearest_palette_color_search;
    import npcs_pkg::*;

    localparam int PALETTE_ENTRIES = 256;
    localparam int SETTLE_CYCLES   = PALETTE_ENTRIES + 8;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_ITEMS     = 110;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = ACT_LOAD;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data = 1'b0;

    int   mismatches;
    int   pending;
    int   queries;
    int   loads;

    logic                 quiet = 1'b0;
    logic                 six_bit_now = 1'b1;
    int                   mode_writes = 0;
    int                   ready_hold = 0;
    logic [ENTRY_W-1:0]   loaded [PALETTE_ENTRIES];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    nearest_palette_color_search #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    npcs_scoreboard #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .mismatches(mismatches),
        .pending   (pending),
        .queries   (queries),
        .loads     (loads)
    );

    // result back-pressure in bursts
    always @(negedge clk)
    begin
        if (quiet)
            m_tready = 1'b1;
        else if (ready_hold > 0)
            ready_hold--;
        else if (m_tready && $urandom_range(0, 2) == 0)
        begin
            m_tready   = 1'b0;
            ready_hold = $urandom_range(0, 12);
        end
        else
        begin
            m_tready   = 1'b1;
            ready_hold = $urandom_range(0, 30);
        end
    end

    function automatic logic [CH_W-1:0] pick_level();
        if ($urandom_range(0, 1) == 1)
            return CH_W'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd64;
            2:       return 8'd128;
            3:       return 8'd192;
            default: return 8'd255;
        endcase
    endfunction

    function automatic logic [ENTRY_W-1:0] random_colour();
        return {pick_level(), pick_level(), pick_level()};
    endfunction

    // colour packs as {blue, green, red}
    task automatic send_beat(logic act, logic [IDX_W-1:0] idx, logic [ENTRY_W-1:0] colour);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {colour, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (act == ACT_LOAD)
            loaded[idx] = colour;
        @(negedge clk);
    endtask

    task automatic load_entry(int idx, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                              logic [CH_W-1:0] b);
        send_beat(ACT_LOAD, IDX_W'(idx), {b, g, r});
    endtask

    task automatic query_colour(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
        send_beat(ACT_QUERY, IDX_W'($urandom_range(0, 255)), {b, g, r});
    endtask

    task automatic fill_random_palette();
        for (int i = 0; i < PALETTE_ENTRIES; i++)
            send_beat(ACT_LOAD, IDX_W'(i), random_colour());
    endtask

    // hold until every result is in and the block has settled
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(logic value);
        drain();
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid   = 1'b0;
        six_bit_now = value;
        mode_writes++;
    endtask

    initial
    begin
        logic [ENTRY_W-1:0] colour;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // all-zero palette: every entry ties
        for (int i = 0; i < PALETTE_ENTRIES; i++)
            load_entry(i, 8'd0, 8'd0, 8'd0);
        query_colour(8'd0, 8'd0, 8'd0);
        query_colour(8'd255, 8'd255, 8'd255);
        query_colour(8'hC3, 8'h40, 8'h3F);

        write_mode(1'b0);
        query_colour(8'd255, 8'd255, 8'd255);
        query_colour(8'd0, 8'd0, 8'd0);
        load_entry(255, 8'd255, 8'd255, 8'd255);
        load_entry(0, 8'd255, 8'd255, 8'd255);
        query_colour(8'd255, 8'd255, 8'd255);
        load_entry(0, 8'd3, 8'd2, 8'd1);
        query_colour(8'd255, 8'd255, 8'd255);

        fill_random_palette();
        colour = loaded[200];
        load_entry(17, colour[7:0], colour[15:8], colour[23:16]);
        query_colour(colour[7:0], colour[15:8], colour[23:16]);
        query_colour(8'd128, 8'd64, 8'd32);

        write_mode(1'b1);
        query_colour(8'hFF, 8'hC0, 8'h3F);
        query_colour(8'h40, 8'h80, 8'hC0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_mode(p % 2 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == RANDOM_PHASES - 1 && n == PHASE_ITEMS / 2)
                    quiet = 1'b1;
                if ($urandom_range(0, 9) < 3)
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        colour = loaded[$urandom_range(0, PALETTE_ENTRIES - 1)];
                        if (six_bit_now && $urandom_range(0, 1) == 1)
                            colour = {2'b00, colour[23:18], 2'b00, colour[15:10],
                                      2'b00, colour[7:2]};
                    end
                    else
                        colour = random_colour();
                    send_beat(ACT_QUERY, IDX_W'($urandom_range(0, 255)), colour);
                end
                else
                    send_beat(ACT_LOAD, IDX_W'($urandom_range(0, 255)), random_colour());
            end
        end

        drain();
        $display("Run covered %0d palette loads and %0d nearest-colour queries,",
                 loads, queries);
        $display("with %0d writes of the six-bit source mode and gaps on both channels.",
                 mode_writes);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("Timeout waiting for results");
        $display("Mismatches found");
        $finish;
    end

endmodule

/* nearest_palette_color_search.f */
src/npcs_pkg.sv
src/npcs_ram.sv
src/npcs_dist.sv
src/nearest_palette_color_search.sv
src/npcs_checker.sv
test/npcs_checker.sv
test/tb_nearest_palette_color_search.sv
